[hw/rtl/sfm_pkg.sv]
package sfm_pkg;

    // Defaults for the top-level parameters
    localparam int              PATTERN_MAX_DEF = 16;
    localparam longint unsigned TEXT_MAX_DEF    = 64'd65536;

    // Fixed widths of the register file and the fields
    localparam int PAT_BYTES = 16;   // bytes held by pattern_low and pattern_high
    localparam int PIDX_W    = 4;    // index into the pattern bytes
    localparam int LEN_W     = 5;
    localparam int POS_W     = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 24;   // found + match_position + overflow, padded to bytes

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2,
        CFG_START_OFFSET   = 2'd3
    } cfg_index_t;

    // One text byte request
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } item_t;

    // One search result
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
        logic             overflow;
    } result_t;

endpackage

[hw/rtl/substring_first_match_top.sv]
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_tvalid/s_tready  | s_tdata[7:0] text_byte, s_tlast last_byte
// m_       | out       | m_tvalid/m_tready  | m_tdata found, match_position, overflow
// cfg_     | in        | cfg_we             | cfg_index, cfg_wdata (64 bits)
//
// One text byte per cycle sustained while no held result stalls a last byte; a byte waits
// in the input register until the search state takes it, and the result of the last byte
// shows on m_ at that same edge. The window compare of up to 16 bytes is combinational
// between input and result registers. Reset (aresetn low, synchronous) clears config and stream state.
// A held result stalls only a following last byte; other bytes keep flowing.
module substring_first_match_top #(
    parameter int              PATTERN_MAX = sfm_pkg::PATTERN_MAX_DEF,
    parameter longint unsigned TEXT_MAX    = sfm_pkg::TEXT_MAX_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,    // [7:0] text_byte
    input  logic                          s_tlast,    // last_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sfm_pkg::OUT_W-1:0]     m_tdata,    // [0] found, [16:1] match_position,
                                                      // [17] overflow, [23:18] zero
    input  logic                          cfg_we,
    input  logic [sfm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfm_pkg::CFG_W-1:0]     cfg_wdata
);

    logic             item_valid;
    sfm_pkg::item_t   item;
    logic             item_take;
    logic             res_ready;
    logic             res_load;
    sfm_pkg::result_t res;

    // A last byte waits until the result register is free
    assign item_take = item_valid && (!item.last_byte || res_ready);

    sfm_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    sfm_search #(
        .PATTERN_MAX (PATTERN_MAX),
        .TEXT_MAX    (TEXT_MAX)
    ) u_search (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (item_take),
        .item      (item),
        .res_load  (res_load),
        .res       (res)
    );

    sfm_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_load  (res_load),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[hw/rtl/sfm_in_stage.sv]
module sfm_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,    // [7:0] text_byte
    input  logic           s_tlast,    // last_byte
    output logic           item_valid,
    output sfm_pkg::item_t item,
    input  logic           item_take
);

    logic           valid_reg;
    sfm_pkg::item_t item_reg;

    // Take a new request when empty or when the held one moves on
    assign s_tready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (item_take) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.text_byte <= s_tdata;
            item_reg.last_byte <= s_tlast;
        end
    end

endmodule

[hw/rtl/sfm_search.sv]
module sfm_search #(
    parameter int              PATTERN_MAX = sfm_pkg::PATTERN_MAX_DEF,
    parameter longint unsigned TEXT_MAX    = sfm_pkg::TEXT_MAX_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [sfm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfm_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        step,
    input  sfm_pkg::item_t              item,
    output logic                        res_load,
    output sfm_pkg::result_t            res
);

    localparam int CW    = $clog2(TEXT_MAX + 64'd1);
    localparam int CMP_W = (CW > sfm_pkg::POS_W) ? CW : sfm_pkg::POS_W;
    localparam int PL    = (PATTERN_MAX < sfm_pkg::PAT_BYTES) ? PATTERN_MAX
                                                              : sfm_pkg::PAT_BYTES;
    localparam logic [CW-1:0] TEXT_MAX_C = CW'(TEXT_MAX);
    localparam logic [sfm_pkg::LEN_W-1:0] PAT_BYTES_C = sfm_pkg::LEN_W'(sfm_pkg::PAT_BYTES);
    localparam logic [CMP_W-1:0] PATTERN_MAX_C = CMP_W'(PATTERN_MAX);

    // Configuration registers
    logic [sfm_pkg::CFG_W-1:0] pattern_low_reg;
    logic [sfm_pkg::CFG_W-1:0] pattern_high_reg;
    logic [sfm_pkg::LEN_W-1:0] pattern_length_reg;
    logic [sfm_pkg::POS_W-1:0] start_offset_reg;

    // Stream state
    logic [7:0]                window_reg [PATTERN_MAX];
    logic [7:0]                window_next [PATTERN_MAX];
    logic [CW-1:0]             count_reg, count_next;
    logic                      match_reg, match_next;
    logic [sfm_pkg::POS_W-1:0] index_reg, index_next;
    logic                      ovf_reg, ovf_next;

    logic [sfm_pkg::PAT_BYTES-1:0][7:0] pat_bytes;
    logic [7:0]                win_shift [PATTERN_MAX];
    logic [CW-1:0]             count_inc;
    logic [CMP_W-1:0]          count_ext, len_ext, start_ext, pos_start;
    logic                      len_ok, eq, hit;
    logic [sfm_pkg::LEN_W-1:0] pidx;

    assign pat_bytes = {pattern_high_reg, pattern_low_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
            start_offset_reg   <= '0;
        end else if (cfg_we) begin
            case (sfm_pkg::cfg_index_t'(cfg_index))
                sfm_pkg::CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_wdata;
                sfm_pkg::CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_wdata;
                sfm_pkg::CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[sfm_pkg::LEN_W-1:0];
                sfm_pkg::CFG_START_OFFSET:   start_offset_reg   <= cfg_wdata[sfm_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Window after the new byte shifts in
    always_comb begin
        for (int k = 0; k < PATTERN_MAX - 1; k++) begin
            win_shift[k] = window_reg[k+1];
        end
        win_shift[PATTERN_MAX-1] = item.text_byte;
    end

    // Qualify the window that ends at the new byte
    assign count_inc = count_reg + CW'(1);
    assign count_ext = CMP_W'(count_inc);
    assign len_ext   = CMP_W'(pattern_length_reg);
    assign start_ext = CMP_W'(start_offset_reg);
    assign pos_start = count_ext - len_ext;
    assign len_ok    = (pattern_length_reg != '0) && (pattern_length_reg <= PAT_BYTES_C)
                       && (len_ext <= PATTERN_MAX_C);

    // Compare newest bytes against the tail of the pattern
    always_comb begin
        eq   = 1'b1;
        pidx = '0;
        for (int j = 0; j < PL; j++) begin
            pidx = pattern_length_reg - sfm_pkg::LEN_W'(1) - sfm_pkg::LEN_W'(j);
            if ((sfm_pkg::LEN_W'(j) < pattern_length_reg) &&
                (win_shift[PATTERN_MAX-1-j] != pat_bytes[pidx[sfm_pkg::PIDX_W-1:0]])) begin
                eq = 1'b0;
            end
        end
    end

    assign hit = !match_reg && len_ok && (count_ext >= len_ext) && (pos_start >= start_ext)
                 && eq;

    // State update and result for the request in hand
    always_comb begin
        window_next = window_reg;
        count_next  = count_reg;
        match_next  = match_reg;
        index_next  = index_reg;
        ovf_next    = ovf_reg;
        res_load    = 1'b0;
        res         = '0;
        if (step) begin
            if (count_reg >= TEXT_MAX_C) begin
                ovf_next = 1'b1;
            end else begin
                window_next = win_shift;
                count_next  = count_inc;
                if (hit) begin
                    match_next = 1'b1;
                    index_next = pos_start[sfm_pkg::POS_W-1:0];
                end
            end
            if (item.last_byte) begin
                res_load = 1'b1;
                if (pattern_length_reg == '0) begin
                    res.found = start_ext < CMP_W'(count_next);
                    res.match_position = res.found ? start_offset_reg : '0;
                end else begin
                    res.found = match_next;
                    res.match_position = match_next ? index_next : '0;
                end
                res.overflow = ovf_next;
                // Clear for the next text
                count_next = '0;
                match_next = 1'b0;
                index_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            match_reg <= 1'b0;
            index_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            match_reg <= match_next;
            index_reg <= index_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Window bytes are only read once this text has filled them
    always_ff @(posedge aclk) begin
        window_reg <= window_next;
    end

endmodule

[hw/rtl/sfm_out_stage.sv]
module sfm_out_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      res_load,
    input  sfm_pkg::result_t          res,
    output logic                      res_ready,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [sfm_pkg::OUT_W-1:0] m_tdata    // [0] found, [16:1] match_position,
                                                 // [17] overflow, [23:18] zero
);

    logic             valid_reg;
    sfm_pkg::result_t res_reg;

    // Free when empty or when the held result leaves this cycle
    assign res_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {6'b0, res_reg.overflow, res_reg.match_position, res_reg.found};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
    import sfm_pkg::*;

    localparam int TEXT_LIMIT   = int'(TEXT_MAX_DEF);
    localparam int RANDOM_ITEMS = 1150;

    // Predicts the search result of each text and checks what comes back
    class first_match_predictor;
        logic [127:0] pattern;
        int unsigned  pat_len;
        int unsigned  start_at;
        logic [7:0]   win [16];
        int unsigned  seen;
        bit           hit;
        int unsigned  first_at;
        bit           ovf;
        result_t      expected_results [$];
        int           failures;

        function new();
            pattern  = '0;
            pat_len  = 0;
            start_at = 0;
            failures = 0;
            clear_text();
        endfunction

        function void clear_text();
            foreach (win[i]) win[i] = 8'h00;
            seen     = 0;
            hit      = 1'b0;
            first_at = 0;
            ovf      = 1'b0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [63:0] v);
            case (idx)
                CFG_PATTERN_LOW:    pattern[63:0]   = v;
                CFG_PATTERN_HIGH:   pattern[127:64] = v;
                CFG_PATTERN_LENGTH: pat_len         = v[4:0];
                CFG_START_OFFSET:   start_at        = v[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // One accepted text byte request
        function void note_byte(logic [7:0] b, logic last);
            bit      eq;
            result_t r;
            if (seen >= TEXT_LIMIT) begin
                // past the trackable length: not searched, not counted
                ovf = 1'b1;
            end else begin
                for (int i = 0; i < 15; i++) win[i] = win[i + 1];
                win[15] = b;
                seen++;
                // newest full window against the pattern, only at or after the offset
                if (!hit && pat_len >= 1 && pat_len <= 16 && seen >= pat_len &&
                    seen - pat_len >= start_at) begin
                    eq = 1'b1;
                    for (int i = 0; i < pat_len; i++)
                        if (win[16 - pat_len + i] !== pattern[8*i +: 8]) eq = 1'b0;
                    if (eq) begin
                        hit      = 1'b1;
                        first_at = seen - pat_len;
                    end
                end
            end
            if (last) begin
                r.found          = 1'b0;
                r.match_position = '0;
                r.overflow       = ovf;
                if (pat_len == 0) begin
                    // empty pattern sits at the offset if the offset is inside the text
                    if (start_at < seen) begin
                        r.found          = 1'b1;
                        r.match_position = start_at[15:0];
                    end
                end else if (hit) begin
                    r.found          = 1'b1;
                    r.match_position = first_at[15:0];
                end
                expected_results.push_back(r);
                clear_text();
            end
        endfunction

        function void flag(string what);
            failures++;
            if (failures <= 10) $display("mismatch: %s", what);
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            result_t want;
            if (expected_results.size() == 0) begin
                flag($sformatf("result %h with no search pending", data));
                return;
            end
            want = expected_results.pop_front();
            if (data[0] !== want.found)
                flag($sformatf("found: expected %0d, got %0d", want.found, data[0]));
            if (data[16:1] !== want.match_position)
                flag($sformatf("match_position: expected %0d, got %0d",
                               want.match_position, data[16:1]));
            if (data[17] !== want.overflow)
                flag($sformatf("overflow: expected %0d, got %0d", want.overflow, data[17]));
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    first_match_predictor book;
    bit                   idle_on = 1'b1;
    int                   items_sent = 0;
    logic [7:0]           text_q [$];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    substring_first_match_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Offer one byte after a random gap and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        book.note_byte(b, last);
        items_sent++;
    endtask

    task automatic send_text(input logic [7:0] bytes [$]);
        foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // Drain all pending results, then give the pipeline time to empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        book.set_reg(idx, v);
    endtask

    task automatic load_config(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [63:0] len_word, input logic [63:0] start_word);
        settle();
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_PATTERN_LENGTH, len_word);
        write_reg(CFG_START_OFFSET, start_word);
        cfg_we <= 1'b0;
    endtask

    // One configuration followed by a few texts, most of them carrying the pattern
    task automatic random_phase();
        logic [7:0]   pat [16];
        logic [127:0] packed_pat;
        logic [7:0]   sym0, sym1;
        logic [7:0]   txt [$];
        bit           narrow;
        int           plen, start, len, p;
        idle_on = ($urandom_range(0, 3) != 0);
        narrow  = $urandom_range(0, 1);
        sym0    = $urandom;
        sym1    = $urandom;
        plen    = $urandom_range(0, 19);
        if (plen > 16) plen = $urandom_range(17, 31);
        for (int i = 0; i < 16; i++) begin
            pat[i] = narrow ? (($urandom_range(0, 1) != 0) ? sym0 : sym1) : 8'($urandom);
            packed_pat[8*i +: 8] = pat[i];
        end
        case ($urandom_range(0, 7))
            0:       start = $urandom_range(0, 65535);
            1:       start = $urandom_range(16, 48);
            default: start = $urandom_range(0, 6);
        endcase
        // upper bits of the narrow registers carry noise
        load_config(packed_pat[63:0], packed_pat[127:64],
                    {32'($urandom), 27'($urandom), 5'(plen)},
                    {32'($urandom), 16'($urandom), 16'(start)});
        repeat ($urandom_range(1, 4)) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 24);
            txt.delete();
            repeat (len)
                txt.push_back(narrow ? (($urandom_range(0, 1) != 0) ? sym0 : sym1)
                                     : 8'($urandom));
            // plant the pattern up to twice, now and then with one bit spoiled
            if (plen >= 1 && plen <= 16 && plen <= len) begin
                repeat ($urandom_range(0, 2)) begin
                    p = $urandom_range(0, len - plen);
                    for (int i = 0; i < plen; i++) txt[p + i] = pat[i];
                    if ($urandom_range(0, 3) == 0)
                        txt[p + $urandom_range(0, plen - 1)] ^= 8'(1 << $urandom_range(0, 7));
                end
            end
            send_text(txt);
        end
    endtask

    // Result side: random stall before each result, then take it
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = idle_on ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) book.check_result(m_tdata);
    end

    initial begin : stimulus
        int base;
        book = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset config: empty pattern at offset 0
        text_q = '{8'h3C};
        send_text(text_q);

        // pattern 00 FF 80 occurs twice, the first one counts
        load_config(64'h0000_0000_0080_FF00, '1, 64'd3, 64'd0);
        text_q = '{8'hFF, 8'h00, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'h80};
        send_text(text_q);

        // start offset past the end of the text
        load_config(64'h0000_0000_0080_FF00, '0, 64'd3, 64'd5);
        text_q = '{8'h00, 8'hFF, 8'h80};
        send_text(text_q);

        // pattern longer than the text left after the offset
        load_config(64'h0000_0000_0080_FF00, '0, 64'd3, 64'd1);
        send_text(text_q);

        // empty pattern: offset at the end, then inside the text
        load_config('1, '0, 64'd0, 64'd2);
        text_q = '{8'hFF, 8'hFF};
        send_text(text_q);
        text_q = '{8'h00, 8'h00, 8'h00};
        send_text(text_q);

        // lengths above 16 never match
        load_config('0, '0, 64'd17, 64'd0);
        text_q = '{8'h00, 8'h00};
        send_text(text_q);
        load_config('0, '0, '1, '1);
        text_q = '{8'h00};
        send_text(text_q);

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) random_phase();

        settle();
        repeat (10) @(posedge aclk);
        if (book.failures == 0 && book.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
